// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/eps_pkg.sv =====
// ----------------------------------------------------------------------------
// eps_pkg
// types and codes shared by the eligible provider min select block
// ----------------------------------------------------------------------------
package eps_pkg;

    // item kinds carried on tuser
    localparam logic [1:0] KIND_ORD   = 2'd0;
    localparam logic [1:0] KIND_FB    = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // decision reasons
    localparam logic [2:0] REASON_INVALID     = 3'd0;
    localparam logic [2:0] REASON_PRIMARY     = 3'd1;
    localparam logic [2:0] REASON_FB_MISMATCH = 3'd2;
    localparam logic [2:0] REASON_FB_USED     = 3'd3;
    localparam logic [2:0] REASON_NONE        = 3'd4;

    // register indexes
    localparam logic [2:0] REG_REQ_MODEL   = 3'd0;
    localparam logic [2:0] REG_REQ_QUALITY = 3'd1;
    localparam logic [2:0] REG_PREF_CLASS  = 3'd2;
    localparam logic [2:0] REG_MAX_QUEUE   = 3'd3;
    localparam logic [2:0] REG_MAX_AGE     = 3'd4;
    localparam logic [2:0] REG_FB_PROVIDER = 3'd5;

    // status flag bits
    localparam int FLAG_ACK      = 0;
    localparam int FLAG_FB_MARK  = 1;
    localparam int FLAG_READY    = 2;
    localparam int FLAG_EVIDENCE = 3;
    localparam int FLAG_DIGEST   = 4;

    typedef struct packed {
        logic [31:0] provider_id;
        logic [31:0] model_id;
        logic [31:0] quality_id;
        logic [15:0] device_class;
        logic [4:0]  status_flags;
        logic [15:0] queue_depth;
        logic [47:0] snapshot_ms;
        logic [47:0] start_ms;
        logic [47:0] now_ms;
    } cand_t;

    typedef struct packed {
        logic [31:0] req_model_id;
        logic [31:0] req_quality_id;
        logic [15:0] preferred_class;
        logic [15:0] max_queue_depth;
        logic [47:0] max_ack_age_ms;
        logic [31:0] fallback_provider_id;
    } cfg_t;

    typedef struct packed {
        logic ord;
        logic fb;
    } elig_t;

    typedef struct packed {
        logic        selected;
        logic [31:0] chosen_provider;
        logic        fallback_used;
        logic [2:0]  reason_code;
    } result_t;

    typedef struct packed {
        logic best_valid;
        logic fallback_seen;
    } set_status_t;

endpackage

// ===== rtl/core/eps_elig.sv =====
// ----------------------------------------------------------------------------
// eps_elig
// eligibility tests of one candidate against the configured requirement
// ----------------------------------------------------------------------------
module eps_elig
(
    input  eps_pkg::cand_t cand,
    input  eps_pkg::cfg_t  cfg,
    output eps_pkg::elig_t elig
);

    logic        flags_ok;
    logic        present_ok;
    logic        queue_ok;
    logic        fresh_ok;
    logic        match_ok;
    logic        common_ok;
    logic        class_ok;
    logic [47:0] age;

    assign flags_ok = cand.status_flags[eps_pkg::FLAG_ACK]
                    & cand.status_flags[eps_pkg::FLAG_READY]
                    & cand.status_flags[eps_pkg::FLAG_EVIDENCE]
                    & cand.status_flags[eps_pkg::FLAG_DIGEST];

    assign present_ok = (cand.provider_id != '0) && (cand.model_id != '0)
                     && (cand.device_class != '0);

    assign queue_ok = cand.queue_depth <= cfg.max_queue_depth;

    // age only matters when now is not behind the snapshot
    assign age      = cand.now_ms - cand.snapshot_ms;
    assign fresh_ok = (cand.snapshot_ms != '0) && (cand.now_ms >= cand.snapshot_ms)
                   && (age <= cfg.max_ack_age_ms);

    assign match_ok = ((cfg.req_model_id == '0) || (cand.model_id == cfg.req_model_id))
                   && ((cfg.req_quality_id == '0) || (cand.quality_id == cfg.req_quality_id));

    assign common_ok = flags_ok & present_ok & queue_ok & fresh_ok & match_ok;

    assign class_ok = (cfg.preferred_class == '0) || (cand.device_class == cfg.preferred_class);

    assign elig.ord = common_ok & ~cand.status_flags[eps_pkg::FLAG_FB_MARK] & class_ok;
    assign elig.fb  = common_ok & (cand.provider_id == cfg.fallback_provider_id);

endmodule

// ===== rtl/core/eps_best.sv =====
// ----------------------------------------------------------------------------
// eps_best
// running minimum of eligible candidates, fallback tracking and decision
// ----------------------------------------------------------------------------
module eps_best
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           kind,
    input  eps_pkg::cand_t       cand,
    input  eps_pkg::elig_t       elig,
    input  eps_pkg::cfg_t        cfg,
    output eps_pkg::result_t     result,
    output eps_pkg::set_status_t status
);

    logic        best_valid_reg,    best_valid_next;
    logic [15:0] best_queue_reg,    best_queue_next;
    logic [47:0] best_start_reg,    best_start_next;
    logic [31:0] best_provider_reg, best_provider_next;
    logic        fallback_seen_reg, fallback_seen_next;
    logic        fallback_ok_reg,   fallback_ok_next;
    logic        better;
    logic        req_invalid;

    // lexicographic compare on (queue, start, provider); full tie keeps the older one
    always_comb
    begin
        if (!best_valid_reg)
        begin
            better = 1'b1;
        end
        else if (cand.queue_depth != best_queue_reg)
        begin
            better = cand.queue_depth < best_queue_reg;
        end
        else if (cand.start_ms != best_start_reg)
        begin
            better = cand.start_ms < best_start_reg;
        end
        else
        begin
            better = cand.provider_id < best_provider_reg;
        end
    end

    always_comb
    begin
        best_valid_next    = best_valid_reg;
        best_queue_next    = best_queue_reg;
        best_start_next    = best_start_reg;
        best_provider_next = best_provider_reg;
        fallback_seen_next = fallback_seen_reg;
        fallback_ok_next   = fallback_ok_reg;
        if (step)
        begin
            case (kind)
                eps_pkg::KIND_ORD:
                begin
                    if (elig.ord && better)
                    begin
                        best_valid_next    = 1'b1;
                        best_queue_next    = cand.queue_depth;
                        best_start_next    = cand.start_ms;
                        best_provider_next = cand.provider_id;
                    end
                end
                eps_pkg::KIND_FB:
                begin
                    fallback_seen_next = 1'b1;
                    fallback_ok_next   = elig.fb;
                end
                eps_pkg::KIND_CLOSE:
                begin
                    best_valid_next    = 1'b0;
                    best_queue_next    = '0;
                    best_start_next    = '0;
                    best_provider_next = '0;
                    fallback_seen_next = 1'b0;
                    fallback_ok_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg    <= 1'b0;
            best_queue_reg    <= '0;
            best_start_reg    <= '0;
            best_provider_reg <= '0;
            fallback_seen_reg <= 1'b0;
            fallback_ok_reg   <= 1'b0;
        end
        else
        begin
            best_valid_reg    <= best_valid_next;
            best_queue_reg    <= best_queue_next;
            best_start_reg    <= best_start_next;
            best_provider_reg <= best_provider_next;
            fallback_seen_reg <= fallback_seen_next;
            fallback_ok_reg   <= fallback_ok_next;
        end
    end

    assign req_invalid = (cfg.req_model_id == '0) || (cfg.req_quality_id == '0)
                      || (cfg.max_ack_age_ms == '0);

    // decision as of the current set, taken on a close item
    always_comb
    begin
        result.selected        = 1'b0;
        result.chosen_provider = '0;
        result.fallback_used   = 1'b0;
        result.reason_code     = eps_pkg::REASON_NONE;
        if (req_invalid)
        begin
            result.reason_code = eps_pkg::REASON_INVALID;
        end
        else if (best_valid_reg)
        begin
            result.selected        = 1'b1;
            result.chosen_provider = best_provider_reg;
            result.reason_code     = eps_pkg::REASON_PRIMARY;
        end
        else if ((cfg.fallback_provider_id != '0) && fallback_seen_reg)
        begin
            if (fallback_ok_reg)
            begin
                result.selected        = 1'b1;
                result.chosen_provider = cfg.fallback_provider_id;
                result.fallback_used   = 1'b1;
                result.reason_code     = eps_pkg::REASON_FB_USED;
            end
            else
            begin
                result.reason_code = eps_pkg::REASON_FB_MISMATCH;
            end
        end
    end

    assign status.best_valid    = best_valid_reg;
    assign status.fallback_seen = fallback_seen_reg;

endmodule

// ===== rtl/core/eligible_provider_min_select.sv =====
// ----------------------------------------------------------------------------
// eligible_provider_min_select
// picks the best eligible provider of a candidate set, with fallback handling
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tdata candidate fields, tuser kind
// m_axis   out  m_axis_tvalid/tready    tdata decision, one word per close
// cfg      in   cfg_valid/cfg_ready     cfg_index register, cfg_data value
//
// one candidate per cycle while s_axis is not held; each word passes the input register,
// where eligibility and the min compare update the set registers
// a close word leaving the input register loads the decision into the output register
// at the next edge, so m_axis_tvalid rises when the output register is loaded
// reset clears the set, the config registers and both valid flags
// only a close word waiting on a full, stalled output register holds s_axis
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eligible_provider_min_select
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // provider_id, model_id, quality_id, device_class, status_flags,
    // queue_depth, snapshot_ms, start_ms, now_ms, zero pad
    input  logic [279:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // selected, chosen_provider, fallback_used, reason_code, zero pad
    output logic [39:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    eps_pkg::cfg_t        cfg_reg;
    eps_pkg::cand_t       cand_in;
    eps_pkg::cand_t       cand_reg;
    logic [1:0]           kind_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    eps_pkg::result_t     result_reg;
    eps_pkg::result_t     result_now;
    eps_pkg::elig_t       elig;
    eps_pkg::set_status_t status;
    logic                 out_free;
    logic                 consume;
    logic                 close_step;
    logic                 in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                eps_pkg::REG_REQ_MODEL:   cfg_reg.req_model_id         <= cfg_data[31:0];
                eps_pkg::REG_REQ_QUALITY: cfg_reg.req_quality_id       <= cfg_data[31:0];
                eps_pkg::REG_PREF_CLASS:  cfg_reg.preferred_class      <= cfg_data[15:0];
                eps_pkg::REG_MAX_QUEUE:   cfg_reg.max_queue_depth      <= cfg_data[15:0];
                eps_pkg::REG_MAX_AGE:     cfg_reg.max_ack_age_ms       <= cfg_data;
                eps_pkg::REG_FB_PROVIDER: cfg_reg.fallback_provider_id <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cand_in.provider_id  = s_axis_tdata[31:0];
    assign cand_in.model_id     = s_axis_tdata[63:32];
    assign cand_in.quality_id   = s_axis_tdata[95:64];
    assign cand_in.device_class = s_axis_tdata[111:96];
    assign cand_in.status_flags = s_axis_tdata[116:112];
    assign cand_in.queue_depth  = s_axis_tdata[132:117];
    assign cand_in.snapshot_ms  = s_axis_tdata[180:133];
    assign cand_in.start_ms     = s_axis_tdata[228:181];
    assign cand_in.now_ms       = s_axis_tdata[276:229];

    // a close word needs room in the output register, others never wait
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && ((kind_reg != eps_pkg::KIND_CLOSE) || out_free);
    assign close_step    = consume && (kind_reg == eps_pkg::KIND_CLOSE);
    assign s_axis_tready = !in_valid_reg || consume;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cand_reg <= cand_in;
            kind_reg <= s_axis_tuser;
        end
    end

    eps_elig u_elig
    (
        .cand (cand_reg),
        .cfg  (cfg_reg),
        .elig (elig)
    );

    eps_best u_best
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (consume),
        .kind   (kind_reg),
        .cand   (cand_reg),
        .elig   (elig),
        .cfg    (cfg_reg),
        .result (result_now),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (close_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_step)
        begin
            result_reg <= result_now;
        end
    end

    assign m_axis_tvalid        = out_valid_reg;
    assign m_axis_tdata[0]      = result_reg.selected;
    assign m_axis_tdata[32:1]   = result_reg.chosen_provider;
    assign m_axis_tdata[33]     = result_reg.fallback_used;
    assign m_axis_tdata[36:34]  = result_reg.reason_code;
    assign m_axis_tdata[39:37]  = '0;

    `ASSERT_NEXT(a_close_loads_result, close_step, out_valid_reg)
    `ASSERT_IMPLIES(a_result_from_close, $rose(out_valid_reg), $past(close_step))
    `ASSERT_NEXT(a_close_clears_set, close_step, !status.best_valid && !status.fallback_seen)
    `ASSERT_IMPLIES(a_no_choice_zeroed, out_valid_reg && !result_reg.selected,
        (result_reg.chosen_provider == '0) && !result_reg.fallback_used)

endmodule
